@@ hdl/ubs_pkg.sv @@
// ----------------------------------------------------------------------------
// ubs_pkg - shared types and constants for the uberblock best selector
// Record layouts for slot beats, decoded candidates and the kept best slot,
// plus the summary field codes and the byte swap helper.
// ----------------------------------------------------------------------------
package ubs_pkg;

	typedef logic [63:0] word_t;

	// on-disk header constants
	localparam word_t       UB_MAGIC       = 64'h0000_0000_00ba_b10c;
	localparam word_t       UB_MAX_VERSION = 64'd5000;
	localparam int unsigned VERSION_W      = 13;
	// label is 256 KiB: label field starts at bit 18, ring starts at 128 KiB
	localparam int unsigned LABEL_SHIFT    = 18;
	localparam int unsigned PSIZE_HI_W     = 64 - LABEL_SHIFT;
	// four labels take 1 MiB: psize under that means bits 63:20 are all zero
	localparam int unsigned MIN_DEV_SHIFT  = 20;
	localparam int unsigned SLOT_SHIFT     = 10;

	// summary field codes
	localparam logic [4:0] FC_COUNT    = 5'd0;
	localparam logic [4:0] FC_OFFSET   = 5'd1;
	localparam logic [4:0] FC_TXG      = 5'd2;
	localparam logic [4:0] FC_VERSION  = 5'd3;
	localparam logic [4:0] FC_GUID     = 5'd4;
	localparam logic [4:0] FC_TIME     = 5'd5;
	localparam logic [4:0] FC_LABEL    = 5'd6;
	localparam logic [4:0] FC_SLOT     = 5'd7;
	localparam logic [4:0] FC_ORDER    = 5'd8;
	localparam logic [4:0] FC_ASIZE    = 5'd9;
	localparam logic [4:0] FC_VDEV     = 5'd10;
	localparam logic [4:0] FC_ROFFSET  = 5'd11;
	localparam logic [4:0] FC_EMBEDDED = 5'd12;
	localparam logic [4:0] FC_LSIZE    = 5'd13;
	localparam logic [4:0] FC_PSIZE    = 5'd14;
	localparam logic [4:0] FC_COMP     = 5'd15;
	localparam logic [4:0] FC_CKSUM    = 5'd16;
	localparam logic [4:0] FC_BTYPE    = 5'd17;
	localparam logic [4:0] FC_LEVEL    = 5'd18;
	localparam logic [4:0] FC_BIRTH    = 5'd19;
	localparam logic [4:0] FC_LAST     = FC_BIRTH;

	// raw slot beat as loaded from the ring
	typedef struct packed {
		word_t      magic;
		word_t      version;
		word_t      txg;
		word_t      guid_total;
		word_t      timestamp;
		word_t      dva0;
		word_t      dva1;
		word_t      prop;
		word_t      birth;
		logic [1:0] label;
		logic [6:0] slot;
	} slot_in_t;

	// decoded root block pointer
	typedef struct packed {
		logic [32:0] asize;
		logic [23:0] vdev;
		word_t       roffset;
		logic        embedded;
		logic [25:0] lsize;
		logic [25:0] psize;
		logic [6:0]  comp;
		logic [7:0]  cksum;
		logic [7:0]  blk_type;
		logic [4:0]  level;
		word_t       birth;
	} root_t;

	// one uberblock's summary fields
	typedef struct packed {
		word_t                offset;
		word_t                txg;
		logic [VERSION_W-1:0] version;
		word_t                guid_total;
		word_t                timestamp;
		logic [1:0]           label;
		logic [6:0]           slot;
		logic                 big;
		root_t                root;
	} ub_t;

	// decoder output: hit marks a valid candidate
	typedef struct packed {
		logic hit;
		ub_t  ub;
	} cand_t;

	// kept state
	typedef struct packed {
		logic [31:0] count;
		ub_t         ub;
	} best_t;

	// per-cycle step control from the input stage
	typedef struct packed {
		logic slot_go;
		logic end_go;
	} step_t;

	function automatic word_t swap64(input word_t v);
		word_t r;
		for (int i = 0; i < 8; i++) begin
			r[8*i +: 8] = v[8*(7-i) +: 8];
		end
		return r;
	endfunction

endpackage

@@ hdl/ubs_slot_decode.sv @@
// ----------------------------------------------------------------------------
// ubs_slot_decode - byte order detection and header decode of one slot
// Swaps the words of big-endian slots, checks magic, version and txg, places
// the slot on disk and splits out the root block pointer fields.
// ----------------------------------------------------------------------------
module ubs_slot_decode (
	input  ubs_pkg::slot_in_t                   slot,
	input  logic                                dev_small,
	input  logic [ubs_pkg::PSIZE_HI_W-1:0]      psize_hi,
	output ubs_pkg::cand_t                      cand
);
	import ubs_pkg::*;

	logic      le_ok;
	logic      be_ok;
	word_t     w_version;
	word_t     w_txg;
	word_t     w_guid;
	word_t     w_time;
	word_t     w_dva0;
	word_t     w_dva1;
	word_t     w_prop;
	word_t     w_birth;
	logic [PSIZE_HI_W-1:0] off_hi;

	// magic in either order, little-endian checked first
	assign le_ok = (slot.magic == UB_MAGIC);
	assign be_ok = !le_ok && (swap64(slot.magic) == UB_MAGIC);

	// words in host order
	always_comb begin
		w_version = be_ok ? swap64(slot.version)    : slot.version;
		w_txg     = be_ok ? swap64(slot.txg)        : slot.txg;
		w_guid    = be_ok ? swap64(slot.guid_total) : slot.guid_total;
		w_time    = be_ok ? swap64(slot.timestamp)  : slot.timestamp;
		w_dva0    = be_ok ? swap64(slot.dva0)       : slot.dva0;
		w_dva1    = be_ok ? swap64(slot.dva1)       : slot.dva1;
		w_prop    = be_ok ? swap64(slot.prop)       : slot.prop;
		w_birth   = be_ok ? swap64(slot.birth)      : slot.birth;
	end

	// labels 2 and 3 sit at the end of the aligned device
	assign off_hi = (slot.label[1] ? psize_hi : '0)
		+ {{(PSIZE_HI_W-2){1'b0}}, slot.label};

	always_comb begin
		cand.hit = !dev_small && (le_ok || be_ok)
			&& (w_version != '0) && (w_version <= UB_MAX_VERSION)
			&& (w_txg != '0);

		cand.ub.offset     = {off_hi, 1'b1, slot.slot, {SLOT_SHIFT{1'b0}}};
		cand.ub.txg        = w_txg;
		cand.ub.version    = w_version[VERSION_W-1:0];
		cand.ub.guid_total = w_guid;
		cand.ub.timestamp  = w_time;
		cand.ub.label      = slot.label;
		cand.ub.slot       = slot.slot;
		cand.ub.big        = be_ok;

		// root block pointer
		cand.ub.root.asize    = {w_dva0[23:0], 9'd0};
		cand.ub.root.vdev     = w_dva0[55:32];
		cand.ub.root.roffset  = {w_dva1[54:0], 9'd0};
		cand.ub.root.embedded = w_prop[39];
		cand.ub.root.lsize    = {({1'b0, w_prop[15:0]} + 17'd1), 9'd0};
		cand.ub.root.psize    = {({1'b0, w_prop[31:16]} + 17'd1), 9'd0};
		cand.ub.root.comp     = w_prop[38:32];
		cand.ub.root.cksum    = w_prop[47:40];
		cand.ub.root.blk_type = w_prop[55:48];
		cand.ub.root.level    = w_prop[60:56];
		cand.ub.root.birth    = w_birth;
	end

endmodule

@@ hdl/ubs_best_track.sv @@
// ----------------------------------------------------------------------------
// ubs_best_track - candidate count and best uberblock register
// Counts valid candidates with saturation and keeps the best by txg, then
// timestamp. Cleared by reset and by the end-of-scan step.
// ----------------------------------------------------------------------------
module ubs_best_track (
	input  logic           clk,
	input  logic           arst_n,
	input  ubs_pkg::step_t step,
	input  ubs_pkg::cand_t cand,
	output ubs_pkg::best_t best_q
);
	import ubs_pkg::*;

	logic  wins;
	best_t best_d;

	// higher txg wins; on a tie the later timestamp wins
	assign wins = (cand.ub.txg > best_q.ub.txg)
		|| ((cand.ub.txg == best_q.ub.txg) && (cand.ub.timestamp > best_q.ub.timestamp));

	always_comb begin
		best_d = best_q;
		if (step.slot_go && cand.hit) begin
			if (best_q.count != '1) begin
				best_d.count = best_q.count + 32'd1;
			end
			if (wins) begin
				best_d.ub = cand.ub;
				// embedded pointers carry no sizes
				if (cand.ub.root.embedded) begin
					best_d.ub.root.lsize = best_q.ub.root.lsize;
					best_d.ub.root.psize = best_q.ub.root.psize;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q <= '0;
		end else if (step.end_go) begin
			best_q <= '0;
		end else begin
			best_q <= best_d;
		end
	end

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step.end_go |=> (best_q.count == '0) && (best_q.ub.txg == '0))
		else $error("state not cleared after end of scan");

	a_txg_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		!step.end_go |=> best_q.ub.txg >= $past(best_q.ub.txg))
		else $error("best txg went backwards within a scan");

	a_no_best_without_count: assert property (@(posedge clk) disable iff (!arst_n)
		(best_q.count == '0) |-> (best_q.ub.txg == '0))
		else $error("best slot held with no candidate counted");

endmodule

@@ hdl/ubs_summary_emit.sv @@
// ----------------------------------------------------------------------------
// ubs_summary_emit - coded summary sequencer and output register
// Takes a snapshot of the best state at end of scan, then walks the twenty
// field codes, one result beat per cycle while the sink does not stall.
// ----------------------------------------------------------------------------
module ubs_summary_emit (
	input  logic           clk,
	input  logic           arst_n,
	input  ubs_pkg::step_t step,
	input  ubs_pkg::best_t best,
	output logic           busy_q,
	output logic           result_valid_q,
	input  logic           result_stall,
	output logic [4:0]     field_code_q,
	output ubs_pkg::word_t field_value_q,
	output logic           last_of_run_q
);
	import ubs_pkg::*;

	best_t      snap_q;
	logic [4:0] idx_q;
	logic       out_free;

	function automatic word_t field_sel(input best_t b, input logic [4:0] code);
		word_t v;
		v = '0;
		unique case (code)
			FC_COUNT:    v = {32'd0, b.count};
			FC_OFFSET:   v = b.ub.offset;
			FC_TXG:      v = b.ub.txg;
			FC_VERSION:  v = {{(64-VERSION_W){1'b0}}, b.ub.version};
			FC_GUID:     v = b.ub.guid_total;
			FC_TIME:     v = b.ub.timestamp;
			FC_LABEL:    v = {62'd0, b.ub.label};
			FC_SLOT:     v = {57'd0, b.ub.slot};
			FC_ORDER:    v = {63'd0, b.ub.big};
			FC_ASIZE:    v = {31'd0, b.ub.root.asize};
			FC_VDEV:     v = {40'd0, b.ub.root.vdev};
			FC_ROFFSET:  v = b.ub.root.roffset;
			FC_EMBEDDED: v = {63'd0, b.ub.root.embedded};
			FC_LSIZE:    v = {38'd0, b.ub.root.lsize};
			FC_PSIZE:    v = {38'd0, b.ub.root.psize};
			FC_COMP:     v = {57'd0, b.ub.root.comp};
			FC_CKSUM:    v = {56'd0, b.ub.root.cksum};
			FC_BTYPE:    v = {56'd0, b.ub.root.blk_type};
			FC_LEVEL:    v = {59'd0, b.ub.root.level};
			FC_BIRTH:    v = b.ub.root.birth;
			default:     v = '0;
		endcase
		return v;
	endfunction

	assign out_free = !result_valid_q || !result_stall;

	// snapshot of the best state, taken when the end beat leaves the input stage
	always_ff @(posedge clk) begin
		if (step.end_go) begin
			snap_q <= best;
		end
	end

	// field sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= '0;
		end else if (step.end_go) begin
			busy_q <= 1'b1;
			idx_q  <= FC_COUNT;
		end else if (busy_q && out_free) begin
			idx_q <= idx_q + 5'd1;
			if (idx_q == FC_LAST) begin
				busy_q <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (out_free) begin
			result_valid_q <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && busy_q) begin
			field_code_q  <= idx_q;
			field_value_q <= field_sel(snap_q, idx_q);
			last_of_run_q <= (idx_q == FC_LAST);
		end
	end

	a_last_code: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && last_of_run_q) |-> (field_code_q == FC_LAST))
		else $error("last beat of run carries wrong field code");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		step.end_go |-> !busy_q)
		else $error("new summary started while one is still draining");

	a_full_run: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> ($past(idx_q) == FC_LAST))
		else $error("summary run ended before the last field");

endmodule

@@ hdl/uberblock_best_selector_top.sv @@
// ----------------------------------------------------------------------------
// uberblock_best_selector_top - streaming uberblock best-slot selector
// Input register, slot decoder, best tracker and summary sequencer; the
// device size register sets label placement and the minimum device check.
// ----------------------------------------------------------------------------
// Slot beats: one per cycle while no end beat waits; a slot reaches the best
//   state in the cycle after it is taken into the input register.
// End beat: input register, sequencer and snapshot, then twenty beats at one
//   per cycle if not stalled; a later end beat holds the input to the last beat.
// Reset (arst_n low, asynchronous): counts, best fields and device size zero, so
//   slot beats are ignored until a size of 1 MiB or more is written.
module uberblock_best_selector_top (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [63:0]           device_size_bytes,
	// slot channel
	input  logic                  item_valid,
	output logic                  item_stall,
	input  logic [63:0]           magic_word,
	input  logic [63:0]           version_word,
	input  logic [63:0]           txg_word,
	input  logic [63:0]           guid_sum_word,
	input  logic [63:0]           timestamp_word,
	input  logic [63:0]           dva_word_zero,
	input  logic [63:0]           dva_word_one,
	input  logic [63:0]           blkptr_prop_word,
	input  logic [63:0]           birth_word,
	input  logic [1:0]            label_number,
	input  logic [6:0]            slot_number,
	input  logic                  end_of_scan,
	// result channel
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic [4:0]            field_code,
	output logic [63:0]           field_value,
	output logic                  last_of_run
);
	import ubs_pkg::*;

	logic                  dev_small_q;
	logic [PSIZE_HI_W-1:0] psize_hi_q;
	logic                  valid_s1;
	logic                  end_s1;
	slot_in_t              slot_s1;
	logic                  s1_go;
	logic                  s1_load;
	logic                  emit_busy;
	step_t                 step;
	cand_t                 cand;
	best_t                 best;

	// device size: keep the too-small flag and aligned size minus four labels
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_small_q <= 1'b1;
			psize_hi_q  <= '0;
		end else if (cfg_valid && cfg_ready) begin
			dev_small_q <= (device_size_bytes[63:MIN_DEV_SHIFT] == '0);
			psize_hi_q  <= device_size_bytes[63:LABEL_SHIFT] - PSIZE_HI_W'(4);
		end
	end

	// input stage: slot beats always advance, an end beat waits for the sequencer
	assign s1_go      = valid_s1 && (!end_s1 || !emit_busy);
	assign s1_load    = !valid_s1 || s1_go;
	assign item_stall = !s1_load;

	assign step.slot_go = s1_go && !end_s1;
	assign step.end_go  = s1_go && end_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_load) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load && item_valid) begin
			end_s1             <= end_of_scan;
			slot_s1.magic      <= magic_word;
			slot_s1.version    <= version_word;
			slot_s1.txg        <= txg_word;
			slot_s1.guid_total <= guid_sum_word;
			slot_s1.timestamp  <= timestamp_word;
			slot_s1.dva0       <= dva_word_zero;
			slot_s1.dva1       <= dva_word_one;
			slot_s1.prop       <= blkptr_prop_word;
			slot_s1.birth      <= birth_word;
			slot_s1.label      <= label_number;
			slot_s1.slot       <= slot_number;
		end
	end

	ubs_slot_decode u_decode (
		.slot      (slot_s1),
		.dev_small (dev_small_q),
		.psize_hi  (psize_hi_q),
		.cand      (cand)
	);

	ubs_best_track u_track (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.cand   (cand),
		.best_q (best)
	);

	ubs_summary_emit u_emit (
		.clk            (clk),
		.arst_n         (arst_n),
		.step           (step),
		.best           (best),
		.busy_q         (emit_busy),
		.result_valid_q (result_valid),
		.result_stall   (result_stall),
		.field_code_q   (field_code),
		.field_value_q  (field_value),
		.last_of_run_q  (last_of_run)
	);

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb - self-checking bench for uberblock_best_selector_top
// Streams uberblock slot beats and end beats through the block under several
// device sizes, tracks the best slot in a local model and compares each
// summary beat, field by field, with the expected summary in order.
// ----------------------------------------------------------------------------
module tb;
	import ubs_pkg::*;

	localparam word_t       LABEL_BYTES  = 64'd262144;   // 256 KiB label
	localparam word_t       RING_START   = 64'd131072;   // 2 pads + phys area
	localparam word_t       SLOT_BYTES   = 64'd1024;
	localparam word_t       MIN_PSIZE    = 64'd1048576;  // four labels
	localparam word_t       ALL_ONES     = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam int unsigned SETTLE       = 10;
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int unsigned LIMIT_CYCLES = 2000000;

	typedef struct packed {
		slot_in_t hdr;
		logic     last;
	} beat_t;

	typedef struct packed {
		logic [4:0] code;
		word_t      value;
		logic       last;
	} summary_t;

	// DUT ports
	logic        clk               = 1'b0;
	logic        arst_n            = 1'b0;
	logic        cfg_valid         = 1'b0;
	logic        cfg_ready;
	logic [63:0] device_size_bytes = '0;
	logic        item_valid        = 1'b0;
	logic        item_stall;
	logic [63:0] magic_word        = '0;
	logic [63:0] version_word      = '0;
	logic [63:0] txg_word          = '0;
	logic [63:0] guid_sum_word     = '0;
	logic [63:0] timestamp_word    = '0;
	logic [63:0] dva_word_zero     = '0;
	logic [63:0] dva_word_one      = '0;
	logic [63:0] blkptr_prop_word  = '0;
	logic [63:0] birth_word        = '0;
	logic [1:0]  label_number      = '0;
	logic [6:0]  slot_number       = '0;
	logic        end_of_scan       = 1'b0;
	logic        result_valid;
	logic        result_stall      = 1'b0;
	logic [4:0]  field_code;
	logic [63:0] field_value;
	logic        last_of_run;

	// bench state
	beat_t       slot_q [$];
	summary_t    summary_q [$];
	beat_t       cur_beat       = '0;
	int unsigned issued_count   = 0;
	int unsigned taken_count    = 0;
	int unsigned gap_left       = 0;
	int unsigned stall_left     = 0;
	int unsigned mismatch_count = 0;
	int unsigned cycle_count    = 0;
	bit          quiet          = 1'b0;
	bit          pressure_armed = 1'b0;
	logic        hold_off       = 1'b0;

	// model of the selector
	word_t       dev_size    = '0;
	logic [31:0] cand_count  = '0;
	word_t       best_offset = '0;
	word_t       best_txg    = '0;
	logic [12:0] best_ver    = '0;
	word_t       best_guid   = '0;
	word_t       best_ts     = '0;
	logic [1:0]  best_label  = '0;
	logic [6:0]  best_slot   = '0;
	logic        best_big    = 1'b0;
	word_t       root_fld [FC_ASIZE:FC_LAST] = '{default: '0};

	uberblock_best_selector_top dut (
		.clk               (clk),
		.arst_n            (arst_n),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.device_size_bytes (device_size_bytes),
		.item_valid        (item_valid),
		.item_stall        (item_stall),
		.magic_word        (magic_word),
		.version_word      (version_word),
		.txg_word          (txg_word),
		.guid_sum_word     (guid_sum_word),
		.timestamp_word    (timestamp_word),
		.dva_word_zero     (dva_word_zero),
		.dva_word_one      (dva_word_one),
		.blkptr_prop_word  (blkptr_prop_word),
		.birth_word        (birth_word),
		.label_number      (label_number),
		.slot_number       (slot_number),
		.end_of_scan       (end_of_scan),
		.result_valid      (result_valid),
		.result_stall      (result_stall),
		.field_code        (field_code),
		.field_value       (field_value),
		.last_of_run       (last_of_run)
	);

	always #5 clk = ~clk;

	function automatic word_t rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic word_t byte_rev(word_t v);
		return {<<8{v}};
	endfunction

	// mostly short gaps, a few long ones
	function automatic int unsigned draw_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic void clear_best();
		cand_count  = '0;
		best_offset = '0;
		best_txg    = '0;
		best_ver    = '0;
		best_guid   = '0;
		best_ts     = '0;
		best_label  = '0;
		best_slot   = '0;
		best_big    = 1'b0;
		foreach (root_fld[i]) root_fld[i] = '0;
	endfunction

	function automatic word_t summary_field(logic [4:0] code);
		case (code)
			FC_COUNT:   return 64'(cand_count);
			FC_OFFSET:  return best_offset;
			FC_TXG:     return best_txg;
			FC_VERSION: return 64'(best_ver);
			FC_GUID:    return best_guid;
			FC_TIME:    return best_ts;
			FC_LABEL:   return 64'(best_label);
			FC_SLOT:    return 64'(best_slot);
			FC_ORDER:   return 64'(best_big);
			default:    return root_fld[code];
		endcase
	endfunction

	// fold one accepted beat into the model; end beats queue the summary
	function automatic void track_beat(beat_t b);
		word_t psz, base, prop;
		word_t w [9];
		logic  big;
		if (b.last) begin
			for (int c = FC_COUNT; c <= FC_LAST; c++)
				summary_q.push_back('{code: 5'(c), value: summary_field(5'(c)),
					last: (c == FC_LAST)});
			clear_best();
			return;
		end
		psz = dev_size - (dev_size % LABEL_BYTES);
		if (psz < MIN_PSIZE) return;
		if (b.hdr.magic == UB_MAGIC) big = 1'b0;
		else if (byte_rev(b.hdr.magic) == UB_MAGIC) big = 1'b1;
		else return;
		w[0] = b.hdr.magic;
		w[1] = b.hdr.version;
		w[2] = b.hdr.txg;
		w[3] = b.hdr.guid_total;
		w[4] = b.hdr.timestamp;
		w[5] = b.hdr.dva0;
		w[6] = b.hdr.dva1;
		w[7] = b.hdr.prop;
		w[8] = b.hdr.birth;
		if (big) foreach (w[i]) w[i] = byte_rev(w[i]);
		if (w[1] == 0 || w[1] > UB_MAX_VERSION || w[2] == 0) return;
		if (cand_count != 32'hFFFF_FFFF) cand_count++;
		// higher txg wins, then strictly later timestamp
		if (w[2] < best_txg || (w[2] == best_txg && w[4] <= best_ts)) return;
		base = 64'(b.hdr.label) * LABEL_BYTES;
		if (b.hdr.label >= 2) base += psz - MIN_PSIZE;
		best_offset = base + RING_START + 64'(b.hdr.slot) * SLOT_BYTES;
		best_txg    = w[2];
		best_ver    = w[1][12:0];
		best_guid   = w[3];
		best_ts     = w[4];
		best_label  = b.hdr.label;
		best_slot   = b.hdr.slot;
		best_big    = big;
		prop = w[7];
		root_fld[FC_ASIZE]    = (w[5] & 64'hFF_FFFF) << 9;
		root_fld[FC_VDEV]     = (w[5] >> 32) & 64'hFF_FFFF;
		root_fld[FC_ROFFSET]  = (w[6] & 64'h7FFF_FFFF_FFFF_FFFF) << 9;
		root_fld[FC_EMBEDDED] = 64'(prop[39]);
		// embedded pointers leave the size fields alone
		if (!prop[39]) begin
			root_fld[FC_LSIZE] = ((prop & 64'hFFFF) + 1) << 9;
			root_fld[FC_PSIZE] = (((prop >> 16) & 64'hFFFF) + 1) << 9;
		end
		root_fld[FC_COMP]  = (prop >> 32) & 64'h7F;
		root_fld[FC_CKSUM] = (prop >> 40) & 64'hFF;
		root_fld[FC_BTYPE] = (prop >> 48) & 64'hFF;
		root_fld[FC_LEVEL] = (prop >> 56) & 64'h1F;
		root_fld[FC_BIRTH] = w[8];
	endfunction

	function automatic void note_mismatch(string msg);
		mismatch_count++;
		if (mismatch_count <= 10) $display("%s", msg);
	endfunction

	// slot beat from host-order words; big-endian slots are stored swapped
	function automatic beat_t make_slot(logic big, word_t ver, word_t txg, word_t ts,
			logic [1:0] lbl, logic [6:0] slt, word_t prop);
		beat_t b;
		b.hdr.magic      = big ? byte_rev(UB_MAGIC) : UB_MAGIC;
		b.hdr.version    = big ? byte_rev(ver) : ver;
		b.hdr.txg        = big ? byte_rev(txg) : txg;
		b.hdr.guid_total = rand64();
		b.hdr.timestamp  = big ? byte_rev(ts) : ts;
		b.hdr.dva0       = rand64();
		b.hdr.dva1       = rand64();
		b.hdr.prop       = big ? byte_rev(prop) : prop;
		b.hdr.birth      = rand64();
		b.hdr.label      = lbl;
		b.hdr.slot       = slt;
		b.last           = 1'b0;
		return b;
	endfunction

	function automatic beat_t make_end();
		beat_t b;
		b = make_slot(1'($urandom_range(0, 1)), rand64(), rand64(), rand64(),
			2'($urandom_range(0, 3)), 7'($urandom_range(0, 127)), rand64());
		if ($urandom_range(0, 1)) b.hdr.magic = rand64();
		b.last = 1'b1;
		return b;
	endfunction

	// mostly valid candidates with close txgs, some bad headers, some noise
	function automatic beat_t random_slot();
		int unsigned kind, pick;
		word_t       ver, txg, ts;
		beat_t       b;
		kind = $urandom_range(0, 99);
		pick = $urandom_range(0, 19);
		ver  = (pick == 0) ? 64'd1 : (pick == 1) ? UB_MAX_VERSION : 64'($urandom_range(1, 5000));
		txg  = ($urandom_range(0, 19) == 0) ? rand64() : 64'($urandom_range(1, 40));
		ts   = ($urandom_range(0, 9) == 0) ? rand64() : 64'($urandom_range(0, 6));
		if (kind >= 65 && kind < 80) begin
			case ($urandom_range(0, 3))
				0: ver = '0;
				1: ver = UB_MAX_VERSION + 1 + $urandom_range(0, 1000);
				2: ver = rand64() | 64'h8000_0000_0000_0000;
				default: txg = '0;
			endcase
		end
		b = make_slot(1'($urandom_range(0, 1)), ver, txg, ts, 2'($urandom_range(0, 3)),
			7'($urandom_range(0, 127)), rand64());
		if (kind >= 80)
			b.hdr.magic = $urandom_range(0, 1) ? rand64() :
				b.hdr.magic ^ (64'd1 << $urandom_range(0, 63));
		return b;
	endfunction

	task automatic offer(beat_t b);
		slot_q.push_back(b);
		issued_count++;
	endtask

	task automatic write_device_size(word_t v);
		@(posedge clk);
		cfg_valid         <= 1'b1;
		device_size_bytes <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		dev_size = v;
	endtask

	// wait until every beat is taken and every summary beat has come back
	task automatic drain();
		while (issued_count != taken_count || summary_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic queue_random_run(int unsigned n, int unsigned end_every);
		for (int unsigned i = 0; i < n; i++) begin
			if ($urandom_range(1, end_every) == 1) offer(make_end());
			else offer(random_slot());
		end
		offer(make_end());
	endtask

	task automatic run_phase(word_t size, int unsigned n, int unsigned end_every);
		quiet = ($urandom_range(0, 3) == 0);
		write_device_size(size);
		queue_random_run(n, end_every);
		drain();
	endtask

	// slot channel driver
	always @(posedge clk) begin
		logic vld;
		vld = item_valid;
		if (arst_n) begin
			if (item_valid && !item_stall) begin
				track_beat(cur_beat);
				taken_count++;
				gap_left = draw_gap();
				vld = 1'b0;
			end
			if (!vld) begin
				if (gap_left != 0) gap_left--;
				else if (slot_q.size() != 0) begin
					cur_beat = slot_q.pop_front();
					vld = 1'b1;
				end
			end
		end
		item_valid       <= vld;
		magic_word       <= cur_beat.hdr.magic;
		version_word     <= cur_beat.hdr.version;
		txg_word         <= cur_beat.hdr.txg;
		guid_sum_word    <= cur_beat.hdr.guid_total;
		timestamp_word   <= cur_beat.hdr.timestamp;
		dva_word_zero    <= cur_beat.hdr.dva0;
		dva_word_one     <= cur_beat.hdr.dva1;
		blkptr_prop_word <= cur_beat.hdr.prop;
		birth_word       <= cur_beat.hdr.birth;
		label_number     <= cur_beat.hdr.label;
		slot_number      <= cur_beat.hdr.slot;
		end_of_scan      <= cur_beat.last;
	end

	// result monitor and stall generator
	always @(posedge clk) begin
		logic     st;
		summary_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (summary_q.size() == 0) begin
				note_mismatch($sformatf("unexpected beat: code %0d value %h last %b",
					field_code, field_value, last_of_run));
			end else begin
				want = summary_q.pop_front();
				if (field_code !== want.code || field_value !== want.value ||
						last_of_run !== want.last)
					note_mismatch($sformatf(
						"mismatch: exp code %0d value %h last %b, got code %0d value %h last %b",
						want.code, want.value, want.last,
						field_code, field_value, last_of_run));
			end
		end
		st = 1'b0;
		if (stall_left != 0) begin
			stall_left--;
			st = 1'b1;
		end else if ($urandom_range(0, 4) == 0) begin
			stall_left = draw_gap();
			st = (stall_left != 0);
		end
		result_stall <= st || hold_off;
	end

	// long receiver hold-off so the block backs up into its input
	initial begin
		wait (pressure_armed);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_off <= 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("** uberblock_best_selector_top: FAILED **");
			$finish;
		end
	end

	// phase sequencer
	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset size is zero: slots ignored, summary all zero
		queue_random_run(4, 100);
		drain();

		// just under four labels after alignment
		write_device_size(64'h0000_0000_000F_FFFF);
		queue_random_run(4, 100);
		drain();

		// directed cases on the largest device
		write_device_size(ALL_ONES);
		offer(make_slot(1'b0, 64'd1, 64'd1, 64'd5, 2'd0, 7'd0, 64'h0123_4567_0000_0010));
		offer(make_slot(1'b1, UB_MAX_VERSION, 64'd2, 64'd0, 2'd3, 7'd127, 64'd0));
		offer(make_slot(1'b0, 64'd0, 64'd9, 64'd1, 2'd1, 7'd1, rand64()));
		offer(make_slot(1'b1, UB_MAX_VERSION + 1, 64'd9, 64'd1, 2'd1, 7'd2, rand64()));
		offer(make_slot(1'b0, ALL_ONES, 64'd9, 64'd1, 2'd1, 7'd3, rand64()));
		offer(make_slot(1'b1, 64'd3, 64'd0, 64'd1, 2'd1, 7'd4, rand64()));
		begin
			beat_t bad;
			bad = make_slot(1'b0, 64'd3, 64'd9, 64'd1, 2'd2, 7'd5, rand64());
			bad.hdr.magic = rand64();
			offer(bad);
			bad.hdr.magic = UB_MAGIC | 64'h8000_0000_0000_0000;
			offer(bad);
		end
		// equal txg with equal timestamp: earlier best stays
		offer(make_slot(1'b0, 64'd4, 64'd2, 64'd0, 2'd1, 7'd9, rand64()));
		// equal txg: lower, equal, then higher timestamp
		offer(make_slot(1'b0, 64'd10, 64'd3, 64'd10, 2'd0, 7'd10, 64'd0));
		offer(make_slot(1'b1, 64'd11, 64'd3, 64'd9, 2'd1, 7'd11, rand64()));
		offer(make_slot(1'b0, 64'd12, 64'd3, 64'd10, 2'd2, 7'd12, rand64()));
		offer(make_slot(1'b1, 64'd13, 64'd3, 64'd11, 2'd3, 7'd13, 64'h0000_0000_1234_5678));
		// embedded root pointer keeps the earlier sizes
		offer(make_slot(1'b0, 64'd14, 64'd4, 64'd0, 2'd2, 7'd14, ALL_ONES));
		offer(make_slot(1'b1, UB_MAX_VERSION, ALL_ONES, ALL_ONES, 2'd3, 7'd127,
			64'hFFFF_FF7F_FFFF_FFFF));
		offer(make_end());
		// nothing since the clear: all-zero summary
		offer(make_end());
		// embedded first best: sizes stay zero
		offer(make_slot(1'b0, 64'd7, 64'd5, 64'd1, 2'd2, 7'd5, 64'h0000_0080_0000_0000));
		offer(make_slot(1'b1, 64'd4999, 64'd6, 64'd2, 2'd1, 7'd64, rand64()));
		offer(make_end());
		drain();

		// exactly four labels
		run_phase(64'h0000_0000_0010_0000, 60, 10);
		run_phase(rand64(), 90, 10);
		run_phase(64'($urandom_range(32'h0010_0000, 32'h4000_0000)), 90, 12);

		// back-pressure: output held while beats keep coming
		quiet = 1'b0;
		write_device_size(ALL_ONES);
		queue_random_run(40, 4);
		pressure_armed = 1'b1;
		drain();

		run_phase(64'd0, 5, 100);
		run_phase(ALL_ONES, 70, 10);

		if (summary_q.size() != 0) note_mismatch("expected summary beats never arrived");
		if (mismatch_count == 0) begin
			$display("** uberblock_best_selector_top: PASSED **");
		end else begin
			$display("** uberblock_best_selector_top: FAILED **");
		end
		$finish;
	end

endmodule
